// File: rtl/fbb_pkg.sv
package fbb_pkg;

  // Default geometry of the frame and size of the source bitmap store.
  localparam int unsigned FRAME_WIDTH_DEF  = 128;
  localparam int unsigned FRAME_HEIGHT_DEF = 64;
  localparam int unsigned SOURCE_BYTES_DEF = 2048;

  // Stream payload widths.
  localparam int unsigned OP_W       = 3;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 8;

  // Width of an unclipped source byte address: (src_y + row) * stride + col / 8.
  localparam int unsigned SRC_EXT_W = 21;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 3'd0,
    OP_SET   = 3'd1,
    OP_GET   = 3'd2,
    OP_FILL  = 3'd3,
    OP_LOAD  = 3'd4,
    OP_BLIT  = 3'd5
  } opcode_e;

  typedef struct packed {
    logic source_fault;
    logic read_value;
  } result_t;

endpackage

// File: rtl/mono_framebuffer_blitter_top.sv
// Monochrome frame buffer blitter with clipping.
// Commands arrive on the slave stream: tuser carries the opcode (clear, set pixel,
// get pixel, fill rectangle, load source byte, blit) and tdata the operands. Every
// command gives exactly one result item on the master stream, with the pixel read
// by a get in bit 0 and the source fault flag of a blit in bit 1.
// Commands are executed one at a time. A fill or a blit walks its clipped pixels;
// the single write port of the frame memory sets that pace of one pixel per cycle.
// A clear sweeps the frame memory one pixel per cycle. After reset the same
// clearing pass runs and s_axis_tready_o stays low until it is done. The source
// store is not cleared and must be loaded before it is blitted from.
// A finished result waits in an output register; while the receiver stalls, the
// block still accepts and runs the next command and holds that one's result
// until the register is free.
module mono_framebuffer_blitter_top #(
  parameter int unsigned FRAME_WIDTH  = fbb_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = fbb_pkg::FRAME_HEIGHT_DEF,
  parameter int unsigned SOURCE_BYTES = fbb_pkg::SOURCE_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // pos_x[15:0], pos_y[31:16], width[41:32], height[51:42], pixel_value[52],
  // src_x[64:53], src_y[76:65], src_stride[84:77], src_addr[95:85], src_byte[103:96]
  input  logic [fbb_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // opcode[2:0]
  input  logic [fbb_pkg::OP_W-1:0]        s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // read_value[0], source_fault[1], zero padding[7:2]
  output logic [fbb_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);

  localparam int unsigned FD  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned FAW = $clog2(FD);
  localparam int unsigned SAW = $clog2(SOURCE_BYTES);

  logic             out_valid_q;
  fbb_pkg::result_t out_q;
  logic             out_free, res_valid;
  fbb_pkg::result_t res;

  logic           fwe, fwdata, fre, frdata;
  logic [FAW-1:0] fwaddr, fraddr;
  logic           swe, sre;
  logic [SAW-1:0] swaddr, sraddr;
  logic [7:0]     swdata, srdata;

  // The output register is free when empty or being taken this cycle.
  assign out_free = !out_valid_q || m_axis_tready_i;

  fbb_seq #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .SOURCE_BYTES(SOURCE_BYTES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .in_user_i  (s_axis_tuser_i),
    .out_free_i (out_free),
    .res_valid_o(res_valid),
    .res_o      (res),
    .fwe_o      (fwe),
    .fwaddr_o   (fwaddr),
    .fwdata_o   (fwdata),
    .fre_o      (fre),
    .fraddr_o   (fraddr),
    .frdata_i   (frdata),
    .swe_o      (swe),
    .swaddr_o   (swaddr),
    .swdata_o   (swdata),
    .sre_o      (sre),
    .sraddr_o   (sraddr),
    .srdata_i   (srdata)
  );

  fbb_frame_mem #(
    .DEPTH(FD)
  ) u_frame_mem (
    .clk_i  (clk_i),
    .we_i   (fwe),
    .waddr_i(fwaddr),
    .wdata_i(fwdata),
    .re_i   (fre),
    .raddr_i(fraddr),
    .rdata_o(frdata)
  );

  fbb_src_mem #(
    .DEPTH(SOURCE_BYTES)
  ) u_src_mem (
    .clk_i  (clk_i),
    .we_i   (swe),
    .waddr_i(swaddr),
    .wdata_i(swdata),
    .re_i   (sre),
    .raddr_i(sraddr),
    .rdata_o(srdata)
  );

  // Result register towards the master stream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(fbb_pkg::OUT_DATA_W - 2){1'b0}}, out_q.source_fault,
                            out_q.read_value};

endmodule

// File: rtl/fbb_frame_mem.sv
module fbb_frame_mem #(
  parameter int unsigned DEPTH = fbb_pkg::FRAME_WIDTH_DEF * fbb_pkg::FRAME_HEIGHT_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  // One bit per pixel, row-major.
  logic mem [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fbb_src_mem.sv
module fbb_src_mem #(
  parameter int unsigned DEPTH = fbb_pkg::SOURCE_BYTES_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fbb_seq.sv
module fbb_seq #(
  parameter int unsigned FRAME_WIDTH  = fbb_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = fbb_pkg::FRAME_HEIGHT_DEF,
  parameter int unsigned SOURCE_BYTES = fbb_pkg::SOURCE_BYTES_DEF,
  localparam int unsigned FD  = FRAME_WIDTH * FRAME_HEIGHT,
  localparam int unsigned FAW = $clog2(FD),
  localparam int unsigned SAW = $clog2(SOURCE_BYTES)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fbb_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic [fbb_pkg::OP_W-1:0]       in_user_i,
  input  logic                           out_free_i,
  output logic                           res_valid_o,
  output fbb_pkg::result_t               res_o,
  output logic                           fwe_o,
  output logic [FAW-1:0]                 fwaddr_o,
  output logic                           fwdata_o,
  output logic                           fre_o,
  output logic [FAW-1:0]                 fraddr_o,
  input  logic                           frdata_i,
  output logic                           swe_o,
  output logic [SAW-1:0]                 swaddr_o,
  output logic [7:0]                     swdata_o,
  output logic                           sre_o,
  output logic [SAW-1:0]                 sraddr_o,
  input  logic [7:0]                     srdata_i
);

  localparam int unsigned CW = $clog2(FRAME_WIDTH + 1);
  localparam int unsigned RW = $clog2(FRAME_HEIGHT + 1);
  localparam int unsigned XW = fbb_pkg::SRC_EXT_W;
  localparam logic signed [17:0] XMAX = 18'(FRAME_WIDTH);
  localparam logic signed [17:0] YMAX = 18'(FRAME_HEIGHT);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SETUP = 8'b0000_0010,
    S_BASE  = 8'b0000_0100,
    S_WALK  = 8'b0000_1000,
    S_DRAIN = 8'b0001_0000,
    S_GETRD = 8'b0010_0000,
    S_CLEAR = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Command fields, captured at acceptance.
  fbb_pkg::opcode_e   op_q;
  logic signed [15:0] px_q, py_q;
  logic [9:0]         w_q, h_q;
  logic               val_q;
  logic [11:0]        sx_q, sy_q;
  logic [7:0]         stride_q;
  logic [10:0]        saddr_q;
  logic [7:0]         sbyte_q;

  // Clipped destination window, walk counters and running bases.
  logic [CW-1:0]  dc0_q, dc1_q, c_q;
  logic [RW-1:0]  dr0_q, dr1_q, r_q;
  logic [FAW-1:0] frow_q, clr_q;
  logic [XW-1:0]  srow_q;
  logic [12:0]    scol0_q, scol_q;

  // Blit write-back stage, in the cycle after the source read.
  logic           p_v_q, p_oob_q;
  logic [FAW-1:0] p_addr_q;
  logic [2:0]     p_bit_q;

  logic pend_q, fault_q, rd_q;

  function automatic logic [CW-1:0] clip_x(input logic signed [17:0] v);
    if (v < 18'sd0) begin
      clip_x = '0;
    end else if (v > XMAX) begin
      clip_x = CW'(FRAME_WIDTH);
    end else begin
      clip_x = CW'(v);
    end
  endfunction

  function automatic logic [RW-1:0] clip_y(input logic signed [17:0] v);
    if (v < 18'sd0) begin
      clip_y = '0;
    end else if (v > YMAX) begin
      clip_y = RW'(FRAME_HEIGHT);
    end else begin
      clip_y = RW'(v);
    end
  endfunction

  logic                accept;
  logic                one_px, draw_op, empty, oob, last_col, last_row, hit;
  logic [9:0]          w_eff, h_eff;
  logic signed [17:0]  xe, ye, rel_c, rel_r;
  logic [CW-1:0]       c_nx;
  logic [RW-1:0]       r_nx;
  logic [FAW-1:0]      faddr;
  logic [XW-1:0]       sext_addr;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  assign one_px  = (op_q == fbb_pkg::OP_SET) || (op_q == fbb_pkg::OP_GET);
  assign draw_op = one_px || (op_q == fbb_pkg::OP_FILL) || (op_q == fbb_pkg::OP_BLIT);
  assign w_eff   = one_px ? 10'd1 : w_q;
  assign h_eff   = one_px ? 10'd1 : h_q;
  assign xe      = 18'(px_q);
  assign ye      = 18'(py_q);
  assign rel_c   = $signed(18'(dc0_q)) - xe;
  assign rel_r   = $signed(18'(dr0_q)) - ye;
  assign empty   = (clip_x(xe + $signed(18'(w_eff))) <= clip_x(xe)) ||
                   (clip_y(ye + $signed(18'(h_eff))) <= clip_y(ye));

  assign c_nx      = c_q + CW'(1);
  assign r_nx      = r_q + RW'(1);
  assign last_col  = (c_nx == dc1_q);
  assign last_row  = (r_nx == dr1_q);
  assign faddr     = frow_q + FAW'(c_q);
  assign sext_addr = srow_q + XW'(scol_q[12:3]);
  assign oob       = (sext_addr >= XW'(SOURCE_BYTES));
  assign hit       = p_v_q && !p_oob_q && srdata_i[3'd7 - p_bit_q];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        if (op_q == fbb_pkg::OP_CLEAR) begin
          state_d = S_CLEAR;
        end else if (draw_op && !empty) begin
          state_d = S_BASE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_BASE: state_d = S_WALK;
      S_WALK: begin
        if (last_col && last_row) begin
          if (op_q == fbb_pkg::OP_GET) begin
            state_d = S_GETRD;
          end else if (op_q == fbb_pkg::OP_BLIT) begin
            state_d = S_DRAIN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DRAIN: state_d = S_DONE;
      S_GETRD: state_d = S_DONE;
      S_CLEAR: begin
        if (clr_q == FAW'(FD - 1)) begin
          state_d = pend_q ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      fault_q <= 1'b0;
      rd_q    <= 1'b0;
      p_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      p_v_q   <= (state_q == S_WALK) && (op_q == fbb_pkg::OP_BLIT);
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            pend_q  <= 1'b1;
            fault_q <= 1'b0;
            rd_q    <= 1'b0;
          end
        end
        S_SETUP: clr_q <= '0;
        S_WALK: begin
          if (op_q == fbb_pkg::OP_BLIT && oob) begin
            fault_q <= 1'b1;
          end
        end
        S_GETRD: rd_q <= frdata_i;
        S_CLEAR: clr_q <= clr_q + FAW'(1);
        S_DONE: begin
          if (out_free_i) begin
            pend_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= fbb_pkg::opcode_e'(in_user_i);
      px_q     <= in_data_i[15:0];
      py_q     <= in_data_i[31:16];
      w_q      <= in_data_i[41:32];
      h_q      <= in_data_i[51:42];
      val_q    <= in_data_i[52];
      sx_q     <= in_data_i[64:53];
      sy_q     <= in_data_i[76:65];
      stride_q <= in_data_i[84:77];
      saddr_q  <= in_data_i[95:85];
      sbyte_q  <= in_data_i[103:96];
    end
    if (state_q == S_SETUP) begin
      dc0_q <= clip_x(xe);
      dc1_q <= clip_x(xe + $signed(18'(w_eff)));
      dr0_q <= clip_y(ye);
      dr1_q <= clip_y(ye + $signed(18'(h_eff)));
    end
    if (state_q == S_BASE) begin
      frow_q  <= FAW'(32'(dr0_q) * FRAME_WIDTH);
      srow_q  <= XW'((13'(sy_q) + rel_r[12:0]) * stride_q);
      scol0_q <= 13'(sx_q) + rel_c[12:0];
      scol_q  <= 13'(sx_q) + rel_c[12:0];
      c_q     <= dc0_q;
      r_q     <= dr0_q;
    end
    if (state_q == S_WALK) begin
      if (last_col) begin
        c_q     <= dc0_q;
        r_q     <= r_nx;
        frow_q  <= frow_q + FAW'(FRAME_WIDTH);
        srow_q  <= srow_q + XW'(stride_q);
        scol_q  <= scol0_q;
      end else begin
        c_q    <= c_nx;
        scol_q <= scol_q + 13'd1;
      end
      p_addr_q <= faddr;
      p_bit_q  <= scol_q[2:0];
      p_oob_q  <= oob;
    end
  end

  // Frame port: clearing sweep, set and fill writes, or blit write-back.
  always_comb begin
    fwe_o    = 1'b0;
    fwaddr_o = faddr;
    fwdata_o = val_q;
    if (state_q == S_CLEAR) begin
      fwe_o    = 1'b1;
      fwaddr_o = clr_q;
      fwdata_o = 1'b0;
    end else if (state_q == S_WALK &&
                 (op_q == fbb_pkg::OP_SET || op_q == fbb_pkg::OP_FILL)) begin
      fwe_o = 1'b1;
    end else if (hit) begin
      fwe_o    = 1'b1;
      fwaddr_o = p_addr_q;
      fwdata_o = 1'b1;
    end
  end

  assign fre_o    = (state_q == S_WALK) && (op_q == fbb_pkg::OP_GET);
  assign fraddr_o = faddr;

  assign swe_o    = (state_q == S_SETUP) && (op_q == fbb_pkg::OP_LOAD) &&
                    (17'(saddr_q) < 17'(SOURCE_BYTES));
  assign swaddr_o = SAW'(saddr_q);
  assign swdata_o = sbyte_q;
  assign sre_o    = (state_q == S_WALK) && (op_q == fbb_pkg::OP_BLIT) && !oob;
  assign sraddr_o = SAW'(sext_addr);

  assign res_valid_o       = (state_q == S_DONE) && out_free_i;
  assign res_o.read_value   = rd_q;
  assign res_o.source_fault = fault_q;

endmodule

// File: rtl/mono_framebuffer_blitter_checker.sv
module mono_framebuffer_blitter_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [fbb_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result item changed while stalled");

  // Only a get reads a pixel and only a blit faults, so both flags never show together.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("read value and source fault both set");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[fbb_pkg::OUT_DATA_W-1:2] == '0)
    else $error("result padding bits not zero");

  // Commands run one at a time: the block is busy in the cycle after an acceptance.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command accepted while the previous one runs");

  // The clearing pass after reset holds off commands.
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready_o)
    else $error("command accepted before the frame was cleared");

endmodule

bind mono_framebuffer_blitter_top mono_framebuffer_blitter_checker u_checker (.*);
